@@ hdl/cardf_pkg.sv @@
// ----------------------------------------------------------------------------
// cardf_pkg
// Types, codes and defaults shared by the archive section deframer.
// ----------------------------------------------------------------------------
package cardf_pkg;

  localparam int CID_BYTES_DEF        = 36;
  localparam int MAX_VARINT_BYTES_DEF = 10;
  localparam int LEN_W                = 64;
  localparam int VCNT_W               = 4;

  typedef enum logic [2:0] {
    PH_HLEN  = 3'd0,
    PH_HBODY = 3'd1,
    PH_SLEN  = 3'd2,
    PH_CID   = 3'd3,
    PH_DATA  = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    CLS_HLEN   = 3'd0,
    CLS_HBODY  = 3'd1,
    CLS_SLEN   = 3'd2,
    CLS_CID    = 3'd3,
    CLS_DATA   = 3'd4,
    CLS_REJECT = 3'd5
  } class_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EARLIER = 3'd1,
    ST_LONG    = 3'd2,
    ST_SHORT   = 3'd3,
    ST_TRUNC   = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    class_t           byte_class;
    logic [7:0]       byte_out;
    logic             field_last;
    logic [LEN_W-1:0] length_value;
    status_t          status;
  } out_item_t;

endpackage

@@ hdl/cardf_tagger.sv @@
// ----------------------------------------------------------------------------
// cardf_tagger
// Framing state and per-byte tagging logic; state advances on each beat taken.
// ----------------------------------------------------------------------------
module cardf_tagger #(
  parameter int CID_BYTES        = cardf_pkg::CID_BYTES_DEF,
  parameter int MAX_VARINT_BYTES = cardf_pkg::MAX_VARINT_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  cardf_pkg::in_item_t  item,
  output cardf_pkg::out_item_t result
);
  import cardf_pkg::*;

  localparam int CID_CNT_W = $clog2(CID_BYTES + 1);

  phase_t               phase, phase_next;
  logic [LEN_W-1:0]     acc, acc_next;
  logic [VCNT_W-1:0]    vcnt, vcnt_next;
  logic [LEN_W-1:0]     rem, rem_next;
  logic [CID_CNT_W-1:0] cid_cnt, cid_cnt_next;
  logic                 failed, failed_next;

  logic [6:0]        mul7;
  logic [LEN_W-1:0]  acc_new;
  logic [VCNT_W-1:0] vcnt_new;
  logic              rem_le1;
  logic [LEN_W-1:0]  rem_dec;
  logic              eos;
  class_t            cls;
  status_t           st;
  logic              last;
  logic [LEN_W-1:0]  len;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_HLEN;
      acc     <= '0;
      vcnt    <= '0;
      rem     <= '0;
      cid_cnt <= '0;
      failed  <= 1'b0;
    end else if (advance) begin
      phase   <= phase_next;
      acc     <= acc_next;
      vcnt    <= vcnt_next;
      rem     <= rem_next;
      cid_cnt <= cid_cnt_next;
      failed  <= failed_next;
    end
  end

  always_comb begin
    eos      = item.end_of_stream;
    mul7     = {vcnt, 3'b000} - {3'b000, vcnt};
    acc_new  = acc | ({{(LEN_W-7){1'b0}}, item.data_byte[6:0]} << mul7[5:0]);
    vcnt_new = vcnt + VCNT_W'(1);
    rem_le1  = (rem[LEN_W-1:1] == '0);
    rem_dec  = (rem != '0) ? rem - LEN_W'(1) : '0;

    phase_next   = phase;
    acc_next     = acc;
    vcnt_next    = vcnt;
    rem_next     = rem;
    cid_cnt_next = cid_cnt;
    failed_next  = failed;

    cls  = CLS_REJECT;
    st   = ST_OK;
    last = 1'b0;
    len  = '0;

    if (failed) begin
      st = ST_EARLIER;
    end else begin
      case (phase)
        PH_HBODY, PH_DATA: begin
          cls      = (phase == PH_HBODY) ? CLS_HBODY : CLS_DATA;
          rem_next = rem_dec;
          if (rem_le1) begin
            last       = 1'b1;
            phase_next = PH_SLEN;
            acc_next   = '0;
            vcnt_next  = '0;
          end else if (eos) begin
            st = ST_TRUNC;
          end
        end
        PH_CID: begin
          cls          = CLS_CID;
          rem_next     = rem_dec;
          cid_cnt_next = cid_cnt + CID_CNT_W'(1);
          if (cid_cnt == CID_CNT_W'(CID_BYTES - 1)) begin
            if (eos && !rem_le1) begin
              st = ST_TRUNC;
            end else begin
              last = 1'b1;
              if (rem_le1) begin
                phase_next = PH_SLEN;
                acc_next   = '0;
                vcnt_next  = '0;
              end else begin
                phase_next = PH_DATA;
              end
            end
          end else if (eos) begin
            st = ST_TRUNC;
          end
        end
        default: begin
          cls       = (phase == PH_SLEN) ? CLS_SLEN : CLS_HLEN;
          acc_next  = acc_new;
          vcnt_next = vcnt_new;
          if (item.data_byte[7]) begin
            if (vcnt_new >= VCNT_W'(MAX_VARINT_BYTES)) begin
              st = ST_LONG;
            end else if (eos) begin
              st = ST_TRUNC;
            end
          end else if (phase != PH_SLEN) begin
            if (eos && acc_new != '0) begin
              st = ST_TRUNC;
            end else begin
              last     = 1'b1;
              len      = acc_new;
              rem_next = acc_new;
              if (acc_new == '0) begin
                phase_next = PH_SLEN;
                acc_next   = '0;
                vcnt_next  = '0;
              end else begin
                phase_next = PH_HBODY;
              end
            end
          end else begin
            if (eos) begin
              st = ST_TRUNC;
            end else if (acc_new < LEN_W'(CID_BYTES)) begin
              st  = ST_SHORT;
              len = acc_new;
            end else begin
              last         = 1'b1;
              len          = acc_new;
              rem_next     = acc_new;
              cid_cnt_next = '0;
              phase_next   = PH_CID;
            end
          end
        end
      endcase

      if (st != ST_OK) begin
        cls         = CLS_REJECT;
        last        = 1'b0;
        failed_next = 1'b1;
      end else if (eos) begin
        phase_next = PH_HLEN;
        acc_next   = '0;
        vcnt_next  = '0;
        rem_next   = '0;
      end
    end

    result.byte_class   = cls;
    result.byte_out     = item.data_byte;
    result.field_last   = last;
    result.length_value = len;
    result.status       = st;
  end

endmodule

@@ hdl/car_section_deframer.sv @@
// ----------------------------------------------------------------------------
// car_section_deframer
// Tags each byte of an archive stream with its field, decodes lengths.
// ----------------------------------------------------------------------------
// The src channel carries one archive byte per beat with an end-of-stream
// flag; the tag channel returns one tagged beat per input beat, in order:
// field class, the byte itself, a field-last flag, the decoded varint length
// and a sticky status code.
// An accepted src beat reaches tag_valid through one input register, then
// the tagging logic into the result register. Throughput is one byte per
// cycle while tag is not stalled, as the framing state updates on each beat.
// A stall on tag holds the result register; the input register keeps
// filling until both hold a beat, then src_stall rises in the same cycle.
// Reset empties both registers and returns the framer to the header length
// phase with no error. After end_of_stream on a clean boundary the next byte
// starts a new archive. After an error every byte is rejected until reset.
// ----------------------------------------------------------------------------
module car_section_deframer #(
  parameter int CID_BYTES        = cardf_pkg::CID_BYTES_DEF,
  parameter int MAX_VARINT_BYTES = cardf_pkg::MAX_VARINT_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 src_valid,
  output logic                 src_stall,
  input  cardf_pkg::in_item_t  src_item,
  output logic                 tag_valid,
  input  logic                 tag_stall,
  output cardf_pkg::out_item_t tag_item
);
  import cardf_pkg::*;

  logic      hold_valid;
  in_item_t  hold_item;
  logic      out_free;
  logic      advance;
  out_item_t step_result;

  assign out_free  = !tag_valid || !tag_stall;
  assign advance   = hold_valid && out_free;
  assign src_stall = hold_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!src_stall) begin
      hold_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!src_stall && src_valid) begin
      hold_item <= src_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_valid <= 1'b0;
    end else if (out_free) begin
      tag_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tag_item <= step_result;
    end
  end

  cardf_tagger #(
    .CID_BYTES        (CID_BYTES),
    .MAX_VARINT_BYTES (MAX_VARINT_BYTES)
  ) u_tagger (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (hold_item),
    .result  (step_result)
  );

endmodule

@@ dv/car_section_deframer_tb.sv @@
// ----------------------------------------------------------------------------
// car_section_deframer_tb
// Self-checking bench for the archive section deframer. Archives are sent
// byte by byte with random gaps, and every tagged beat is checked field by
// field against a software framer kept in step with the accepted input.
// Most traffic is clean archives with random sizes and padded varints. A
// burst runs against a long output stall, and the run closes with one
// randomly chosen fatal framing error followed by trailing rejected bytes.
// ----------------------------------------------------------------------------
module car_section_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cardf_pkg::*;

  localparam int CID_LEN      = CID_BYTES_DEF;
  localparam int MAX_VB       = MAX_VARINT_BYTES_DEF;
  localparam int RANDOM_BYTES = 700;
  localparam int LONG_HOLD    = 60;
  localparam int DRAIN_CYCLES = 20;

  logic       clk;
  logic       rst;
  logic       src_valid;
  logic       src_stall;
  in_item_t   src_item;
  logic       tag_valid;
  logic       tag_stall;
  out_item_t  tag_item;

  out_item_t  expected_tags[$];
  int         mismatches;
  int         sent_bytes;
  bit         back_to_back;
  bit         long_hold_req;

  phase_t      fr_phase;
  logic [63:0] fr_acc;
  logic [3:0]  fr_count;
  logic [63:0] fr_left;
  logic        fr_failed;

  car_section_deframer dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_item  (src_item),
    .tag_valid (tag_valid),
    .tag_stall (tag_stall),
    .tag_item  (tag_item)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin : watchdog
    #10_000_000;
    $display("car_section_deframer verification failed");
    $finish;
  end

  function automatic void begin_varint(phase_t p);
    fr_phase = p;
    fr_acc   = '0;
    fr_count = '0;
  endfunction

  function automatic out_item_t frame_byte(in_item_t it);
    out_item_t   r;
    phase_t      ph;
    logic        last;
    status_t     st;
    logic [63:0] len;
    last = 1'b0;
    st   = ST_OK;
    len  = '0;
    r.byte_class = CLS_REJECT;
    r.byte_out   = it.data_byte;
    if (fr_failed) begin
      st = ST_EARLIER;
    end else begin
      ph = fr_phase;
      r.byte_class = class_t'(ph);
      if (ph == PH_HLEN || ph == PH_SLEN) begin
        fr_acc |= 64'(it.data_byte[6:0]) << ((7 * int'(fr_count)) % 64);
        fr_count++;
        if (it.data_byte[7]) begin
          if (fr_count >= MAX_VB) st = ST_LONG;
          else if (it.end_of_stream) st = ST_TRUNC;
        end else if (ph == PH_HLEN) begin
          if (it.end_of_stream && fr_acc != 0) begin
            st = ST_TRUNC;
          end else begin
            last    = 1'b1;
            len     = fr_acc;
            fr_left = fr_acc;
            if (fr_acc == 0) begin_varint(PH_SLEN);
            else fr_phase = PH_HBODY;
          end
        end else begin
          if (it.end_of_stream) begin
            st = ST_TRUNC;
          end else if (fr_acc < 64'(CID_LEN)) begin
            st  = ST_SHORT;
            len = fr_acc;
          end else begin
            last     = 1'b1;
            len      = fr_acc;
            fr_left  = fr_acc;
            fr_phase = PH_CID;
          end
        end
      end else begin
        if (fr_left != 0) fr_left--;
        if (ph == PH_CID) begin
          if (fr_acc - fr_left == 64'(CID_LEN)) begin
            if (it.end_of_stream && fr_left != 0) begin
              st = ST_TRUNC;
            end else begin
              last = 1'b1;
              if (fr_left == 0) begin_varint(PH_SLEN);
              else fr_phase = PH_DATA;
            end
          end else if (it.end_of_stream) begin
            st = ST_TRUNC;
          end
        end else begin
          if (fr_left == 0) begin
            last = 1'b1;
            begin_varint(PH_SLEN);
          end else if (it.end_of_stream) begin
            st = ST_TRUNC;
          end
        end
      end
      if (st != ST_OK) begin
        r.byte_class = CLS_REJECT;
        last         = 1'b0;
        if (st != ST_SHORT) len = '0;
        fr_failed    = 1'b1;
      end else if (it.end_of_stream) begin
        begin_varint(PH_HLEN);
        fr_left = '0;
      end
    end
    r.field_last   = last;
    r.length_value = len;
    r.status       = st;
    return r;
  endfunction

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  function automatic int varint_size(logic [63:0] value);
    int n;
    n = 1;
    while (n < MAX_VB && (value >> (7 * n)) != 0) n++;
    if ($urandom_range(0, 4) == 0) n = $urandom_range(n, MAX_VB);
    return n;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eos);
    in_item_t it;
    int       gap;
    it.data_byte     = b;
    it.end_of_stream = eos;
    gap = back_to_back ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src_valid <= 1'b1;
    src_item  <= it;
    do @(negedge clk); while (src_stall);
    @(posedge clk);
    expected_tags.push_back(frame_byte(it));
    sent_bytes++;
  endtask

  task automatic send_run(input int n, input logic eos_last);
    int i;
    for (i = 0; i < n; i++) send_byte(8'($urandom), eos_last && i == n - 1);
  endtask

  task automatic send_varint(input logic [63:0] value, input int nbytes, input logic eos);
    logic [63:0] rest;
    logic [7:0]  b;
    int          i;
    rest = value;
    for (i = 0; i < nbytes; i++) begin
      b[7]   = (i < nbytes - 1);
      b[6:0] = rest[6:0];
      // bits above bit 63 are dropped by the decoder
      if (i == MAX_VB - 1) b[6:1] = 6'($urandom);
      send_byte(b, eos && i == nbytes - 1);
      rest = rest >> 7;
    end
  endtask

  task automatic send_archive();
    logic [63:0] hdr_len;
    logic [63:0] blk_bytes;
    int          n_sec;
    int          s;
    bit          last;
    hdr_len = ($urandom_range(0, 3) == 0) ? 64'd0 : 64'($urandom_range(1, 12));
    if ($urandom_range(0, 15) == 0) hdr_len = 64'($urandom_range(100, 300));
    n_sec = $urandom_range(0, 3);
    send_varint(hdr_len, varint_size(hdr_len), hdr_len == 0 && n_sec == 0);
    if (hdr_len != 0) send_run(int'(hdr_len), n_sec == 0);
    for (s = 0; s < n_sec; s++) begin
      last      = (s == n_sec - 1);
      blk_bytes = ($urandom_range(0, 3) == 0) ? 64'd0 : 64'($urandom_range(1, 24));
      if ($urandom_range(0, 19) == 0) blk_bytes = 64'($urandom_range(100, 400));
      send_varint(64'(CID_LEN) + blk_bytes, varint_size(64'(CID_LEN) + blk_bytes), 1'b0);
      send_run(CID_LEN, last && blk_bytes == 0);
      if (blk_bytes != 0) send_run(int'(blk_bytes), last);
    end
  endtask

  task automatic test_empty_archive();
    send_byte(8'h00, 1'b1);
    send_varint(64'd0, 2, 1'b1);
  endtask

  task automatic test_header_only();
    send_byte(8'h02, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
  endtask

  task automatic test_long_varint();
    send_byte(8'h81, 1'b0);
    repeat (MAX_VB - 2) send_byte(8'h80, 1'b0);
    send_byte(8'h7e, 1'b0);
    send_byte(8'h5a, 1'b1);
  endtask

  task automatic test_cid_only_section();
    send_byte(8'h00, 1'b0);
    send_varint(64'(CID_LEN), 1, 1'b0);
    send_run(CID_LEN, 1'b1);
  endtask

  task automatic test_random_archives();
    int first;
    first = sent_bytes;
    while (sent_bytes - first < RANDOM_BYTES) begin
      back_to_back = ($urandom_range(0, 3) == 0);
      send_archive();
    end
    back_to_back = 1'b0;
  endtask

  task automatic test_backpressure();
    back_to_back  = 1'b1;
    long_hold_req = 1'b1;
    send_byte(8'h00, 1'b0);
    send_varint(64'(CID_LEN + 200), 2, 1'b0);
    send_run(CID_LEN, 1'b0);
    send_run(200, 1'b1);
    back_to_back = 1'b0;
  endtask

  task automatic test_fatal_error();
    int kind;
    kind = $urandom_range(0, 8);
    case (kind)
      0: begin
        repeat (MAX_VB - 1) send_byte(8'h80 | 8'($urandom_range(0, 127)), 1'b0);
        send_byte(8'h80 | 8'($urandom_range(0, 127)), 1'($urandom));
      end
      1: begin
        send_byte(8'h00, 1'b0);
        send_varint(64'($urandom_range(0, CID_LEN - 1)), varint_size(64'(CID_LEN - 1)),
                    1'b0);
      end
      2: send_byte(8'h80 | 8'($urandom_range(0, 127)), 1'b1);
      3: send_byte(8'($urandom_range(1, 127)), 1'b1);
      4: begin
        send_varint(64'd5, 1, 1'b0);
        send_run(4, 1'b1);
      end
      5: begin
        send_byte(8'h00, 1'b0);
        send_varint(64'(CID_LEN + 100), 2, 1'b1);
      end
      6: begin
        send_byte(8'h00, 1'b0);
        send_varint(64'(CID_LEN + 4), 1, 1'b0);
        send_run(10, 1'b1);
      end
      7: begin
        send_byte(8'h00, 1'b0);
        send_varint(64'(CID_LEN + 4), 1, 1'b0);
        send_run(CID_LEN, 1'b1);
      end
      default: begin
        send_byte(8'h00, 1'b0);
        send_varint(64'(CID_LEN + 4), 1, 1'b0);
        send_run(CID_LEN, 1'b0);
        send_run(2, 1'b1);
      end
    endcase
    repeat ($urandom_range(5, 20)) send_byte(8'($urandom), 1'($urandom));
  endtask

  initial begin : tag_sink
    int        hold;
    int        quiet;
    out_item_t seen;
    out_item_t want;
    tag_stall = 1'b0;
    quiet     = 0;
    do @(posedge clk); while (rst);
    forever begin
      if (long_hold_req) begin
        hold          = LONG_HOLD;
        long_hold_req = 1'b0;
      end else if (quiet > 0) begin
        hold = 0;
        quiet--;
      end else begin
        hold = $urandom_range(0, 5);
        if ($urandom_range(0, 49) == 0) quiet = $urandom_range(20, 60);
      end
      if (hold > 0) begin
        tag_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      tag_stall <= 1'b0;
      do @(negedge clk); while (!tag_valid);
      seen = tag_item;
      @(posedge clk);
      if (expected_tags.size() == 0) begin
        mismatches++;
        $display("%0t tag beat mismatch: expected none actual %p", $time, seen);
      end else begin
        want = expected_tags.pop_front();
        compare_field("byte_class", 64'(want.byte_class), 64'(seen.byte_class));
        compare_field("byte_out", 64'(want.byte_out), 64'(seen.byte_out));
        compare_field("field_last", 64'(want.field_last), 64'(seen.field_last));
        compare_field("length_value", want.length_value, seen.length_value);
        compare_field("status", 64'(want.status), 64'(seen.status));
      end
    end
  end

  initial begin : stimulus
    rst           = 1'b1;
    src_valid     = 1'b0;
    src_item      = '0;
    mismatches    = 0;
    sent_bytes    = 0;
    back_to_back  = 1'b0;
    long_hold_req = 1'b0;
    begin_varint(PH_HLEN);
    fr_left   = '0;
    fr_failed = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_archive();
    test_header_only();
    test_long_varint();
    test_cid_only_section();
    test_random_archives();
    test_backpressure();
    test_fatal_error();

    src_valid <= 1'b0;
    while (expected_tags.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_tags.size() == 0) begin
      $display("car_section_deframer verification clean");
    end else begin
      $display("car_section_deframer verification failed");
    end
    $finish;
  end

endmodule
